// ----- hw/rtl/kcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_pkg
// Types and constants shared by the key click classifier modules.
// ----------------------------------------------------------------------------
package kcc_pkg;

    localparam int KEYS      = 2;
    localparam int TIME_BITS = 32;
    localparam int KEY_BITS  = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CFG_BITS  = 16;

    localparam logic [1:0] REG_CONFIRM = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_LONG    = 2'd2;

    localparam logic [CFG_BITS-1:0] CONFIRM_RESET = 16'd10;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET  = 16'd300;
    localparam logic [CFG_BITS-1:0] LONG_RESET    = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } ev_kind_t;

    typedef enum logic [3:0] {
        PH_RELEASE = 4'b0001,
        PH_CONFIRM = 4'b0010,
        PH_SHORT   = 4'b0100,
        PH_LONG    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_time;
        logic [CFG_BITS-1:0] double_click_window;
        logic [CFG_BITS-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic [KEYS-1:0]      key_levels;
        logic [TIME_BITS-1:0] now_ms;
    } scan_t;

    typedef struct packed {
        ev_kind_t             event_kind;
        logic [KEY_BITS-1:0]  event_key;
    } result_t;

endpackage

// ----- hw/rtl/kcc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_lane
// Debounce and click state machine for one key; state updates on commit.
// ----------------------------------------------------------------------------
module kcc_lane
    import kcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 pressed,
    input  logic [TIME_BITS-1:0] now_ms,
    input  logic                 commit,
    output ev_kind_t             ev_kind
);

    phase_t               phase_reg, phase_next;
    logic [1:0]           count_reg, count_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] release_reg, release_next;
    logic [TIME_BITS-1:0] el_press;
    logic [TIME_BITS-1:0] el_release;
    logic [1:0]           count_inc;

    assign el_press   = now_ms - start_reg;
    assign el_release = now_ms - release_reg;
    assign count_inc  = (count_reg == 2'd3) ? count_reg : count_reg + 2'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        release_next = release_reg;
        ev_kind      = EV_NONE;
        case (phase_reg)
            PH_RELEASE:
            begin
                if (pressed)
                begin
                    phase_next = PH_CONFIRM;
                    start_next = now_ms;
                end
                else if (count_reg != 2'd0 &&
                         el_release > TIME_BITS'(cfg.double_click_window))
                begin
                    count_next = 2'd0;
                    ev_kind    = EV_SINGLE;
                end
            end
            PH_CONFIRM:
            begin
                if (!pressed)
                    phase_next = PH_RELEASE;
                else if (el_press > TIME_BITS'(cfg.debounce_time))
                    phase_next = PH_SHORT;
            end
            PH_SHORT:
            begin
                if (!pressed)
                begin
                    phase_next = PH_RELEASE;
                    count_next = count_inc;
                    if (count_inc == 2'd1)
                        release_next = now_ms;
                    else if (el_release <= TIME_BITS'(cfg.double_click_window))
                    begin
                        count_next = 2'd0;
                        ev_kind    = EV_DOUBLE;
                    end
                end
                else if (el_press > TIME_BITS'(cfg.long_press_time))
                    phase_next = PH_LONG;
            end
            PH_LONG:
            begin
                if (!pressed)
                begin
                    phase_next = PH_RELEASE;
                    ev_kind    = EV_LONG;
                end
            end
            default:
            begin
                phase_next = PH_RELEASE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RELEASE;
            count_reg <= 2'd0;
        end
        else if (commit)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            start_reg   <= start_next;
            release_reg <= release_next;
        end
    end

endmodule

// ----- hw/rtl/kcc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_merge
// Priority merge: lowest key with an event wins, later keys hold state.
// ----------------------------------------------------------------------------
module kcc_merge
    import kcc_pkg::*;
(
    input  ev_kind_t        ev_kind [KEYS],
    output logic [KEYS-1:0] commit_mask,
    output result_t         merged
);

    logic seen;

    always_comb
    begin
        seen              = 1'b0;
        merged.event_kind = EV_NONE;
        merged.event_key  = '0;
        for (int k = 0; k < KEYS; k++)
        begin
            commit_mask[k] = !seen;
            if (!seen && ev_kind[k] != EV_NONE)
            begin
                merged.event_kind = ev_kind[k];
                merged.event_key  = KEY_BITS'(k);
            end
            seen = seen || (ev_kind[k] != EV_NONE);
        end
    end

endmodule

// ----- hw/rtl/key_click_classifier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_click_classifier_core
// Per-key debounce and click classification with a priority merge.
//
//   channel  signals                          payload
//   scan     scan_valid / scan_stall / scan   key levels, time in ms
//   result   result_valid / result_stall      event kind, event key
//   config   wr_en / wr_index / wr_data       three 16-bit timing registers
//
// One scan per cycle while scan_stall is low; each scan gives one result in the cycle after its transfer.
// All key lanes evaluate in the same cycle, the merge picks the event of the lowest key.
// Reset puts every key in release with no pending click; no clearing pass.
// scan_stall is high only while a result is held under result_stall.
// ----------------------------------------------------------------------------
module key_click_classifier_core
    import kcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scan_valid,
    output logic                scan_stall,
    input  scan_t               scan,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [CFG_BITS-1:0] wr_data
);

    cfg_t            cfg_reg;
    logic            valid_reg, valid_next;
    result_t         result_reg;
    logic            scan_xfer;
    ev_kind_t        ev_kind [KEYS];
    logic [KEYS-1:0] commit_mask;
    result_t         merged;

    assign scan_stall = valid_reg && result_stall;
    assign scan_xfer  = scan_valid && !scan_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time       <= CONFIRM_RESET;
            cfg_reg.double_click_window <= WINDOW_RESET;
            cfg_reg.long_press_time     <= LONG_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CONFIRM: cfg_reg.debounce_time       <= wr_data;
                REG_WINDOW:  cfg_reg.double_click_window <= wr_data;
                REG_LONG:    cfg_reg.long_press_time     <= wr_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    for (genvar k = 0; k < KEYS; k++)
    begin : g_lane
        kcc_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg_reg),
            .pressed (!scan.key_levels[k]),
            .now_ms  (scan.now_ms),
            .commit  (scan_xfer && commit_mask[k]),
            .ev_kind (ev_kind[k])
        );
    end

    kcc_merge u_merge
    (
        .ev_kind     (ev_kind),
        .commit_mask (commit_mask),
        .merged      (merged)
    );

    always_comb
    begin
        if (scan_xfer)
            valid_next = 1'b1;
        else if (result_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (scan_xfer)
            result_reg <= merged;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        scan_xfer |=> result_valid)
        else $error("scan transfer gave no result");

    a_none_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_kind == EV_NONE) |-> (result.event_key == '0))
        else $error("event key set without an event");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> (result_valid && result_stall))
        else $error("scan stalled without a held result");
`endif

endmodule
